>>> hw/rtl/unicycle_linearizing_control_sim_core_assert.svh
// Assertion macros for the unicycle linearizing control core.
`ifndef UNICYCLE_LINEARIZING_CONTROL_SIM_CORE_ASSERT_SVH
`define UNICYCLE_LINEARIZING_CONTROL_SIM_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ULC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ULC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ULC_ASSERT_IMP(label, clk, rst, ante, cons)
`define ULC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/ulc_pkg.sv
// Shared types, constants and tables for the unicycle linearizing control core.
package ulc_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CORDIC_ITER_DEF = 16;
   localparam logic [31:0] STEP_TIME_RESET = 32'd429497;
   localparam logic [9:0] SUBSTEP_RESET = 10'd500;
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
   localparam logic [0:0] CSR_STEP_TIME = 1'b0;
   localparam logic [0:0] CSR_SUBSTEPS = 1'b1;

   // datapath operations
   localparam logic [3:0] OP_NOP = 4'd0;
   localparam logic [3:0] OP_LOAD = 4'd1;   // latch command, start divide of dt
   localparam logic [3:0] OP_SPEED = 4'd2;  // speed += accel*T
   localparam logic [3:0] OP_CSTART = 4'd3; // start CORDIC on heading
   localparam logic [3:0] OP_CSTEP = 4'd4;
   localparam logic [3:0] OP_ACCEL = 4'd5;  // new accel, numerator; start div
   localparam logic [3:0] OP_DSTEP = 4'd6;  // one divider step
   localparam logic [3:0] OP_WDONE = 4'd7;
   localparam logic [3:0] OP_POS = 4'd8;    // move pose
   localparam logic [3:0] OP_VEL = 4'd9;    // velocity from sin/cos
   localparam logic [3:0] OP_OUT = 4'd10;

   typedef struct packed {
      logic [3:0] op;
      logic dmode;  // 0: dt divide, 1: turn-rate divide
   } cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic div_done;
      logic last_substep;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      case (i)
         5'd0: return 32'h20000000; 5'd1: return 32'h12E4051E;
         5'd2: return 32'h09FB385B; 5'd3: return 32'h051111D4;
         5'd4: return 32'h028B0D43; 5'd5: return 32'h0145D7E1;
         5'd6: return 32'h00A2F61E; 5'd7: return 32'h00517C55;
         5'd8: return 32'h0028BE53; 5'd9: return 32'h00145F2F;
         5'd10: return 32'h000A2F98; 5'd11: return 32'h000517CC;
         5'd12: return 32'h00028BE6; 5'd13: return 32'h000145F3;
         5'd14: return 32'h0000A2FA; 5'd15: return 32'h0000517D;
         5'd16: return 32'h000028BE; 5'd17: return 32'h0000145F;
         5'd18: return 32'h00000A30; 5'd19: return 32'h00000518;
         5'd20: return 32'h0000028C; 5'd21: return 32'h00000146;
         5'd22: return 32'h000000A3; 5'd23: return 32'h00000051;
         5'd24: return 32'h00000029; 5'd25: return 32'h00000014;
         5'd26: return 32'h0000000A; 5'd27: return 32'h00000005;
         5'd28: return 32'h00000003; 5'd29: return 32'h00000001;
         default: return 32'h0;
      endcase
   endfunction
endpackage

>>> hw/rtl/ulc_if.sv
// Valid/ready channel interfaces for the core.
interface ulc_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] command_x;
   logic signed [31:0] command_y;
   modport source (output valid, command_x, command_y, input ready);
   modport sink (input valid, command_x, command_y, output ready);
endinterface

interface ulc_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] position_x;
   logic signed [31:0] position_y;
   logic [31:0] heading_angle;
   logic signed [31:0] forward_speed;
   logic signed [31:0] turn_rate;
   modport source (output valid, position_x, position_y, heading_angle, forward_speed,
      turn_rate, input ready);
   modport sink (input valid, position_x, position_y, heading_angle, forward_speed,
      turn_rate, output ready);
endinterface

interface ulc_csr_if;
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/unicycle_linearizing_control_sim_core.sv
// Top level of the unicycle linearizing control core.
//  channel | dir | beat
//  req_    | in  | command_x, command_y
//  rsp_    | out | position_x, position_y, heading_angle, forward_speed, turn_rate
//  csr_    | in  | index (0 step_time, 1 substep_count), data
// The two 64-step serial divides and the shared serial CORDIC, which runs once more in every
// substep, set the cost of a tick; N, the substep count, runs as one when it is zero.
// Reset is synchronous; it clears the sequencer, restores the CSR defaults and zeroes the pose and speed.
// A result waits in the output register while the next beat is taken; a finished tick
// holds until that register has drained.
`include "unicycle_linearizing_control_sim_core_assert.svh"
module unicycle_linearizing_control_sim_core #(
   parameter int FRAC_BITS = ulc_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_ITERATIONS = ulc_pkg::CORDIC_ITER_DEF
) (
   input logic clock,
   input logic reset,
   ulc_req_if.sink req,
   ulc_rsp_if.source rsp,
   ulc_csr_if.sink csr
);
   import ulc_pkg::*;
   logic [31:0] step_time_ff;
   logic [9:0] substeps_ff;
   cmd_type cmd;
   sts_type sts;
   logic idle_ready;

   // registers always accept; the user must write them only while idle, the block does not enforce it
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_TIME_RESET;
         substeps_ff <= SUBSTEP_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_STEP_TIME: step_time_ff <= csr.data;
            CSR_SUBSTEPS: substeps_ff <= csr.data[9:0];
            default: ;
         endcase
      end
   end

   assign req.ready = idle_ready;

   ulc_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(idle_ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .sts(sts), .cmd(cmd));

   ulc_datapath #(.FRAC_BITS(FRAC_BITS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .command_x(req.command_x), .command_y(req.command_y),
      .step_time(step_time_ff), .substep_count(substeps_ff),
      .position_x(rsp.position_x), .position_y(rsp.position_y),
      .heading_angle(rsp.heading_angle), .forward_speed(rsp.forward_speed),
      .turn_rate(rsp.turn_rate));

   `ULC_ASSERT_NEXT(a_no_accept_busy, clock, reset, req.valid && req.ready, !req.ready)
   `ULC_ASSERT_NEXT(a_hold_rsp, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `ULC_ASSERT_IMP(a_cfg_range, clock, reset, csr.valid, csr.ready)
endmodule

>>> hw/rtl/ulc_ctrl.sv
// Sequencer for the core: walks each tick through its datapath operations.
module ulc_ctrl #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   output logic out_valid,
   input logic out_ready,
   input ulc_pkg::sts_type sts,
   output ulc_pkg::cmd_type cmd
);
   import ulc_pkg::*;
   localparam logic [3:0] S_IDLE = 4'd0, S_DT = 4'd1, S_SPEED = 4'd2, S_C0 = 4'd3,
      S_C0R = 4'd4, S_ACC = 4'd5, S_DIV = 4'd6, S_WD = 4'd7, S_POS = 4'd8,
      S_C1 = 4'd9, S_C1R = 4'd10, S_VEL = 4'd11, S_OUT = 4'd12, S_HOLD = 4'd13;
   localparam int CW = $clog2(CORDIC_ITERATIONS + 1);
   logic [3:0] state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic ovalid_ff, ovalid_in;

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = ovalid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ovalid_in = ovalid_ff & ~out_ready;
      cmd = '{op: OP_NOP, dmode: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.op = OP_LOAD;
               state_in = S_DT;
            end
         end
         S_DT: begin
            cmd.op = OP_DSTEP;
            if (sts.div_done) state_in = S_SPEED;
         end
         S_SPEED: begin
            cmd.op = OP_SPEED;
            state_in = S_C0;
         end
         S_C0: begin
            cmd.op = OP_CSTART;
            cnt_in = '0;
            state_in = S_C0R;
         end
         S_C0R: begin
            cmd.op = OP_CSTEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CORDIC_ITERATIONS - 1)) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACCEL;
            cmd.dmode = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DSTEP;
            cmd.dmode = 1'b1;
            if (sts.div_done) state_in = S_WD;
         end
         S_WD: begin
            cmd.op = OP_WDONE;
            state_in = S_POS;
         end
         S_POS: begin
            cmd.op = OP_POS;
            state_in = S_C1;
         end
         S_C1: begin
            cmd.op = OP_CSTART;
            cnt_in = '0;
            state_in = S_C1R;
         end
         S_C1R: begin
            cmd.op = OP_CSTEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CORDIC_ITERATIONS - 1)) state_in = S_VEL;
         end
         S_VEL: begin
            cmd.op = OP_VEL;
            state_in = sts.last_substep ? S_OUT : S_POS;
         end
         S_OUT: begin
            if (!ovalid_ff) begin
               cmd.op = OP_OUT;
               ovalid_in = 1'b1;
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ovalid_ff <= ovalid_in;
      end
   end
endmodule

>>> hw/rtl/ulc_datapath.sv
// Arithmetic for the core: CORDIC, shared divider, Euler integrator, output register.
`include "unicycle_linearizing_control_sim_core_assert.svh"
module ulc_datapath #(
   parameter int FRAC_BITS = 16,
   parameter int CORDIC_ITERATIONS = 16
) (
   input logic clock,
   input logic reset,
   input ulc_pkg::cmd_type cmd,
   output ulc_pkg::sts_type sts,
   input logic signed [31:0] command_x,
   input logic signed [31:0] command_y,
   input logic [31:0] step_time,
   input logic [9:0] substep_count,
   output logic signed [31:0] position_x,
   output logic signed [31:0] position_y,
   output logic [31:0] heading_angle,
   output logic signed [31:0] forward_speed,
   output logic signed [31:0] turn_rate
);
   import ulc_pkg::*;
   localparam int DW = 64;  // divider width, holds num*2^FRAC_BITS
   logic signed [31:0] px_ff, py_ff, vx_ff, vy_ff, sp_ff, ac_ff, w_ff;
   logic [31:0] hd_ff, dt_ff;
   logic signed [31:0] ux_ff, uy_ff;
   logic [9:0] n_ff, j_ff;
   // turn rate held as |rate*K| and its sign
   logic [63:0] tm_ff;
   logic tneg_ff;
   // CORDIC
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [32:0] cz_ff;
   logic flip_ff;
   logic [4:0] ci_ff;
   // divider
   logic [DW-1:0] dq_ff, dr_ff, dd_ff;
   logic dneg_ff, dzero_ff;
   logic [6:0] dc_ff;
   logic signed [31:0] opx_ff, opy_ff, osp_ff, ow_ff;
   logic [31:0] ohd_ff;

   logic signed [33:0] cos_v, sin_v;
   assign cos_v = flip_ff ? -cx_ff : cx_ff;
   assign sin_v = flip_ff ? -cy_ff : cy_ff;

   function automatic logic signed [65:0] rshift(input logic signed [65:0] v, input int s);
      logic signed [65:0] t;
      t = v + (66'sd1 <<< s);
      return t >>> (s + 1);
   endfunction

   // rate*K is latched on the velocity update; the angle step is |rate*K| * dt >> 32 >> FRAC
   logic signed [63:0] turns;
   logic [63:0] tmag;
   logic [63:0] hi_p, lo_p, hsum;
   logic [31:0] dstep;
   always_comb begin
      turns = 64'(w_ff) * $signed({1'b0, INV_TWO_PI_Q32});
      tmag = turns[63] ? 64'(-turns) : turns;
      hi_p = {32'd0, tm_ff[63:32]} * {32'd0, dt_ff};
      lo_p = {32'd0, tm_ff[31:0]} * {32'd0, dt_ff};
      hsum = (hi_p + {32'd0, lo_p[63:32]}) >> FRAC_BITS;
      dstep = tneg_ff ? 32'(32'd0 - hsum[31:0]) : hsum[31:0];
   end

   logic signed [65:0] num_c, prod_a, sp_sum;
   logic [31:0] hdn;
   logic [DW:0] dtrial;
   always_comb begin
      num_c = 66'(ux_ff) * 66'(cos_v) + 66'(uy_ff) * 66'(sin_v);
      prod_a = 66'(uy_ff) * 66'(cos_v) - 66'(ux_ff) * 66'(sin_v);
      sp_sum = 66'(sp_ff) + rshift(66'(ac_ff) * $signed({34'd0, step_time}), 31);
      hdn = hd_ff;
      dtrial = {dr_ff[DW-2:0], dq_ff[DW-1]} - {1'b0, dd_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0; py_ff <= '0; vx_ff <= '0; vy_ff <= '0;
         tm_ff <= '0; tneg_ff <= 1'b0;
         sp_ff <= '0; ac_ff <= '0; hd_ff <= '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               ux_ff <= command_x;
               uy_ff <= command_y;
               n_ff <= (substep_count == '0) ? 10'd1 : substep_count;
               j_ff <= '0;
               dq_ff <= {32'd0, step_time};
               dr_ff <= '0;
               dd_ff <= {54'd0, (substep_count == '0) ? 10'd1 : substep_count};
               dneg_ff <= 1'b0;
               dc_ff <= '0;
            end
            OP_SPEED: sp_ff <= sat32(sp_sum);
            OP_CSTART: begin
               flip_ff <= hd_ff[31] ^ hd_ff[30];
               cz_ff <= (hd_ff[31] ^ hd_ff[30]) ? 33'(signed'(hd_ff + 32'h80000000))
                                                : 33'(signed'(hd_ff));
               cx_ff <= 34'(CORDIC_GAIN_Q30);
               cy_ff <= '0;
               ci_ff <= '0;
            end
            OP_CSTEP: begin
               if (!cz_ff[32]) begin
                  cx_ff <= cx_ff - (cy_ff >>> ci_ff);
                  cy_ff <= cy_ff + (cx_ff >>> ci_ff);
                  cz_ff <= cz_ff - 33'(atan_turn(ci_ff));
               end else begin
                  cx_ff <= cx_ff + (cy_ff >>> ci_ff);
                  cy_ff <= cy_ff - (cx_ff >>> ci_ff);
                  cz_ff <= cz_ff + 33'(atan_turn(ci_ff));
               end
               ci_ff <= ci_ff + 1'b1;
            end
            OP_ACCEL: begin
               ac_ff <= sat32(rshift(num_c, 29));
               // numerator floor(prod/2^30) * 2^FRAC, magnitude divide
               dzero_ff <= (sp_ff == 32'sd0);
               dneg_ff <= (prod_a[65] != sp_ff[31]);
               dq_ff <= prod_a[65] ? 64'(-((prod_a >>> 30) <<< FRAC_BITS))
                                   : 64'((prod_a >>> 30) <<< FRAC_BITS);
               dd_ff <= sp_ff[31] ? 64'(-65'(sp_ff)) : 64'(sp_ff);
               dr_ff <= '0;
               dc_ff <= '0;
            end
            OP_DSTEP: begin
               if (!dtrial[DW]) begin
                  dr_ff <= dtrial[DW-1:0];
                  dq_ff <= {dq_ff[DW-2:0], 1'b1};
               end else begin
                  dr_ff <= {dr_ff[DW-2:0], dq_ff[DW-1]};
                  dq_ff <= {dq_ff[DW-2:0], 1'b0};
               end
               dc_ff <= dc_ff + 1'b1;
               if (dc_ff == 7'd63 && !cmd.dmode) dt_ff <= 32'({dq_ff[DW-2:0], !dtrial[DW]});
            end
            OP_WDONE: w_ff <= dzero_ff ? 32'sd0 :
               sat32(dneg_ff ? -66'($signed({1'b0, dq_ff})) : 66'($signed({1'b0, dq_ff})));
            OP_POS: begin
               px_ff <= sat32(66'(px_ff) + rshift(66'(vx_ff) * $signed({34'd0, dt_ff}), 31));
               py_ff <= sat32(66'(py_ff) + rshift(66'(vy_ff) * $signed({34'd0, dt_ff}), 31));
               hd_ff <= hdn + dstep;
            end
            OP_VEL: begin
               vx_ff <= sat32(rshift(66'(sp_ff) * 66'(cos_v), 29));
               vy_ff <= sat32(rshift(66'(sp_ff) * 66'(sin_v), 29));
               tm_ff <= tmag;
               tneg_ff <= turns[63];
               j_ff <= j_ff + 1'b1;
            end
            OP_OUT: begin
               opx_ff <= px_ff;
               opy_ff <= py_ff;
               ohd_ff <= hd_ff;
               osp_ff <= sp_ff;
               ow_ff <= w_ff;
            end
            default: ;
         endcase
      end
   end

   assign sts.cordic_done = (ci_ff == 5'(CORDIC_ITERATIONS));
   assign sts.div_done = (dc_ff == 7'd63);
   assign sts.last_substep = (j_ff + 1'b1 == n_ff);
   assign position_x = opx_ff;
   assign position_y = opy_ff;
   assign heading_angle = ohd_ff;
   assign forward_speed = osp_ff;
   assign turn_rate = ow_ff;

   `ULC_ASSERT_NEXT(a_load_clears_count, clock, reset, cmd.op == OP_LOAD, j_ff == '0)
   `ULC_ASSERT_IMP(a_n_nonzero, clock, reset, cmd.op == OP_VEL, n_ff != '0)
   `ULC_ASSERT_NEXT(a_wzero, clock, reset, cmd.op == OP_WDONE && dzero_ff, w_ff == '0)
endmodule
